[design/ffsc_pkg.sv]
`timescale 1ns / 1ps
package ffsc_pkg;

    // vertex coordinate and result widths
    localparam int COORD_BITS = 18;
    localparam int SHADE_BITS = 16;

    // edge and normal widths, exact for the coordinate width
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * EDGE_BITS;
    localparam int NORM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS   = NORM_BITS;

    // reduced normal and root search widths
    localparam int RED_BITS   = 31;
    localparam int SH_SPAN    = MAG_BITS - RED_BITS;
    localparam int SH_BITS    = $clog2(SH_SPAN + 1);
    localparam int SQ_BITS    = 2 * RED_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int Q_BITS     = SHADE_BITS + 1;
    localparam int ACC_BITS   = SUM_BITS + 2 * Q_BITS + 2;
    localparam int STEPS      = SHADE_BITS + 1;

    localparam logic [SHADE_BITS-1:0] SHADE_MAX = {SHADE_BITS{1'b1}};

    // state carried through one root search step
    typedef struct packed {
        logic                vld;
        logic                vis;
        logic [SUM_BITS-1:0] s;
        logic [ACC_BITS-1:0] r;
        logic [ACC_BITS-1:0] p;
        logic [ACC_BITS-1:0] qs;
        logic [Q_BITS-1:0]   q;
    } step_t;

endpackage

[design/ffsc_in_if.sv]
`timescale 1ns / 1ps
interface ffsc_in_if;
    import ffsc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  a_x;
    logic signed [COORD_BITS-1:0]  a_y;
    logic signed [COORD_BITS-1:0]  a_z;
    logic signed [COORD_BITS-1:0]  b_x;
    logic signed [COORD_BITS-1:0]  b_y;
    logic signed [COORD_BITS-1:0]  b_z;
    logic signed [COORD_BITS-1:0]  c_x;
    logic signed [COORD_BITS-1:0]  c_y;
    logic signed [COORD_BITS-1:0]  c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

[design/ffsc_out_if.sv]
`timescale 1ns / 1ps
interface ffsc_out_if;
    import ffsc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   visible;
    logic [SHADE_BITS-1:0]  shade;

    modport source (output valid, visible, shade, input ready);
    modport sink (input valid, visible, shade, output ready);
endinterface

[design/ffsc_root_step.sv]
`timescale 1ns / 1ps
module ffsc_root_step #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ffsc_pkg::step_t stage_in,
    output ffsc_pkg::step_t stage_out
);
    import ffsc_pkg::*;

    logic [ACC_BITS-1:0] cand;
    logic                take;
    logic                vld_reg;
    step_t               data_reg;
    step_t               stage_next;

    // (q + 2^b)^2 * s = q^2 s + (q s) 2^(b+1) + s 2^(2b)
    always_comb
    begin
        cand = stage_in.p + (stage_in.qs << (BIT + 1))
             + (ACC_BITS'(stage_in.s) << (2 * BIT));
        take = (cand <= stage_in.r);
        stage_next = stage_in;
        if (take)
        begin
            stage_next.p  = cand;
            stage_next.qs = stage_in.qs + (ACC_BITS'(stage_in.s) << BIT);
            stage_next.q  = stage_in.q | (Q_BITS'(1) << BIT);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= stage_next.vld;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= stage_next;
    end

    // stage output with the reset valid bit
    always_comb
    begin
        stage_out     = data_reg;
        stage_out.vld = vld_reg;
    end
endmodule

[design/flat_face_shade_cull.sv]
`timescale 1ns / 1ps
// flat_face_shade_cull: flat lambert shade and back-face cull per triangle
// tri_in  (sink): one request carries the three vertices a, b, c as signed
//                 Q5.12 coordinates; accepted when valid and ready are high
// res_out (source): one request per triangle, in order, with visible and
//                 shade (unsigned Q0.16, zero when culled)
// throughput: one triangle per clock while res_out takes results
// pipeline: six stages form the edges, cross product, range reduction, squares
// and sums, seventeen stages run the bit-by-bit root search (one shade bit
// each), and one output register holds the result
// stalls: the whole pipeline holds while a result waits and res_out.ready is
// low; tri_in.ready is low then, and no request is lost or repeated; while
// the output register is empty or being taken, a new triangle enters each
// cycle
// reset: all valid bits clear, the pipeline is empty and no result is shown
module flat_face_shade_cull (
    input  logic        clk,
    input  logic        rst_n,
    ffsc_in_if.sink     tri_in,
    ffsc_out_if.source  res_out
);
    import ffsc_pkg::*;

    logic en;

    logic                         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [EDGE_BITS-1:0]  e_reg [6];
    logic signed [EDGE_BITS-1:0]  e_next [6];
    logic signed [PROD_BITS-1:0]  p_reg [6];
    logic signed [NORM_BITS-1:0]  nx, ny, nz;
    logic [MAG_BITS-1:0]          mx_reg, my_reg, mz_reg;
    logic                         vis3_reg, vis4_reg, vis5_reg, vis6_reg;
    logic [MAG_BITS-1:0]          mor;
    logic [SH_BITS-1:0]           sh;
    logic [RED_BITS-1:0]          rx_reg, ry_reg, rz_reg;
    logic [SQ_BITS-1:0]           x2_reg, y2_reg, z2_reg;
    logic [SUM_BITS-1:0]          s_reg;
    logic [ACC_BITS-1:0]          r_reg;
    step_t                        chain [STEPS+1];
    logic                         out_valid_reg;
    logic                         visible_reg;
    logic [SHADE_BITS-1:0]        shade_reg;
    logic [SHADE_BITS-1:0]        shade_next;

    // global advance: hold everything while a result waits
    assign en           = !out_valid_reg || res_out.ready;
    assign tri_in.ready = en;

    // edges from the first vertex
    always_comb
    begin
        e_next[0] = EDGE_BITS'(tri_in.b_x) - EDGE_BITS'(tri_in.a_x);
        e_next[1] = EDGE_BITS'(tri_in.b_y) - EDGE_BITS'(tri_in.a_y);
        e_next[2] = EDGE_BITS'(tri_in.b_z) - EDGE_BITS'(tri_in.a_z);
        e_next[3] = EDGE_BITS'(tri_in.c_x) - EDGE_BITS'(tri_in.a_x);
        e_next[4] = EDGE_BITS'(tri_in.c_y) - EDGE_BITS'(tri_in.a_y);
        e_next[5] = EDGE_BITS'(tri_in.c_z) - EDGE_BITS'(tri_in.a_z);
    end

    // cross product terms
    always_comb
    begin
        nx = NORM_BITS'(p_reg[0]) - NORM_BITS'(p_reg[1]);
        ny = NORM_BITS'(p_reg[2]) - NORM_BITS'(p_reg[3]);
        nz = NORM_BITS'(p_reg[4]) - NORM_BITS'(p_reg[5]);
    end

    // common right shift bringing the largest magnitude below 2^31
    always_comb
    begin
        mor = mx_reg | my_reg | mz_reg;
        sh  = '0;
        for (int k = 0; k < SH_SPAN; k++)
        begin
            if ((mor >> (RED_BITS + k)) != '0)
                sh = sh + SH_BITS'(1);
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= tri_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg    <= e_next;
            p_reg[0] <= PROD_BITS'(e_reg[1]) * PROD_BITS'(e_reg[5]);
            p_reg[1] <= PROD_BITS'(e_reg[2]) * PROD_BITS'(e_reg[4]);
            p_reg[2] <= PROD_BITS'(e_reg[2]) * PROD_BITS'(e_reg[3]);
            p_reg[3] <= PROD_BITS'(e_reg[0]) * PROD_BITS'(e_reg[5]);
            p_reg[4] <= PROD_BITS'(e_reg[0]) * PROD_BITS'(e_reg[4]);
            p_reg[5] <= PROD_BITS'(e_reg[1]) * PROD_BITS'(e_reg[3]);
            mx_reg   <= nx[NORM_BITS-1] ? MAG_BITS'(-nx) : MAG_BITS'(nx);
            my_reg   <= ny[NORM_BITS-1] ? MAG_BITS'(-ny) : MAG_BITS'(ny);
            mz_reg   <= nz[NORM_BITS-1] ? MAG_BITS'(-nz) : MAG_BITS'(nz);
            vis3_reg <= !nz[NORM_BITS-1] && (nz != '0);
            rx_reg   <= RED_BITS'(mx_reg >> sh);
            ry_reg   <= RED_BITS'(my_reg >> sh);
            rz_reg   <= RED_BITS'(mz_reg >> sh);
            vis4_reg <= vis3_reg;
            x2_reg   <= SQ_BITS'(rx_reg) * SQ_BITS'(rx_reg);
            y2_reg   <= SQ_BITS'(ry_reg) * SQ_BITS'(ry_reg);
            z2_reg   <= SQ_BITS'(rz_reg) * SQ_BITS'(rz_reg);
            vis5_reg <= vis4_reg;
            s_reg    <= SUM_BITS'(x2_reg) + SUM_BITS'(y2_reg) + SUM_BITS'(z2_reg);
            r_reg    <= ACC_BITS'(z2_reg) << (2 * SHADE_BITS);
            vis6_reg <= vis5_reg;
        end
    end

    // root search seed
    always_comb
    begin
        chain[0].vld = v6_reg;
        chain[0].vis = vis6_reg;
        chain[0].s   = s_reg;
        chain[0].r   = r_reg;
        chain[0].p   = '0;
        chain[0].qs  = '0;
        chain[0].q   = '0;
    end

    // one shade bit per stage, most significant first
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        ffsc_root_step #(
            .BIT (SHADE_BITS - i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // saturate and mask culled faces
    always_comb
    begin
        if (!chain[STEPS].vis)
            shade_next = '0;
        else if (chain[STEPS].q[SHADE_BITS])
            shade_next = SHADE_MAX;
        else
            shade_next = chain[STEPS].q[SHADE_BITS-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain[STEPS].vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            visible_reg <= chain[STEPS].vis;
            shade_reg   <= shade_next;
        end
    end

    assign res_out.valid   = out_valid_reg;
    assign res_out.visible = visible_reg;
    assign res_out.shade   = shade_reg;
endmodule
